### design/wans_pkg.sv
// Shared types, constants and helpers for the weekly alarm next-select unit.
package wans_pkg;

   localparam int ENTRY_COUNT = 7;
   localparam int IDX_W       = 3;
   localparam int SEC_W       = 20;
   localparam int DAY_W       = 17;
   localparam int CNT_W       = 8;
   localparam int REQ_W       = 48;
   localparam int RSP_W       = 48;

   localparam logic [IDX_W-1:0] NO_ENTRY = 3'd7;

   localparam int HOUR_SEC = 3600;
   localparam int MIN_SEC  = 60;
   localparam int DAY_SEC  = 86400;

   typedef enum logic [2:0] {
      ACT_WRITE   = 3'd0,
      ACT_RESCHED = 3'd1,
      ACT_FIRE    = 3'd2,
      ACT_STOP    = 3'd3,
      ACT_TOGGLE  = 3'd4,
      ACT_ENABLE  = 3'd5
   } action_type;

   localparam logic CSR_DAILY  = 1'b0;
   localparam logic CSR_WEEKLY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACT,
      ST_MOD,
      ST_SCAN,
      ST_DONE
   } state_type;

   // one alarm entry (enabled flag kept apart as a per-entry bit)
   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic       weekly;
      logic [2:0] weekday;
      logic       rotating;
   } entry_type;

   // current time as seen by the seconds unit
   typedef struct packed {
      logic [2:0]       weekday;
      logic [4:0]       hour;
      logic [5:0]       minute;
      logic [DAY_W-1:0] total;
   } now_type;

   // request beat, first field in the low bits
   typedef struct packed {
      logic [4:0] pad;
      logic [5:0] now_second;
      logic [5:0] now_minute;
      logic [4:0] now_hour;
      logic [2:0] now_weekday;
      logic       set_rotating;
      logic       set_enabled;
      logic [2:0] set_weekday;
      logic       set_weekly;
      logic [5:0] set_minute;
      logic [4:0] set_hour;
      logic [2:0] entry_index;
      logic [2:0] action;
   } req_item_type;

   // response beat, first field in the low bits
   typedef struct packed {
      logic                   pad;
      logic                   status;
      logic [7:0]             fired_text_index;
      logic                   fired;
      logic [ENTRY_COUNT-1:0] enabled_mask;
      logic [ENTRY_COUNT-1:0] alerting_mask;
      logic [SEC_W-1:0]       seconds_until;
      logic [IDX_W-1:0]       scheduled_index;
   } rsp_item_type;

   function automatic logic [2:0] wday_mod7(input logic [2:0] d);
      return (d == 3'd7) ? 3'd0 : d;
   endfunction

endpackage

### design/wans_secs.sv
// Seconds from the current time to an entry's next occurrence, clamped to at least 1.
module wans_secs (
   input  wans_pkg::entry_type         entry,
   input  wans_pkg::now_type           cur,
   output logic [wans_pkg::SEC_W-1:0]  seconds
);
   import wans_pkg::*;

   logic [DAY_W-1:0]  target;
   logic              passed;
   logic [2:0]        tw;
   logic [2:0]        cw;
   logic [2:0]        wdiff;
   logic [2:0]        days;
   logic [SEC_W-1:0]  day_part;
   logic signed [21:0] diff;

   assign target = DAY_W'(entry.hour) * DAY_W'(HOUR_SEC)
                 + DAY_W'(entry.minute) * DAY_W'(MIN_SEC);

   assign passed = (entry.hour < cur.hour) ||
                   ((entry.hour == cur.hour) && (entry.minute <= cur.minute));

   assign tw    = wday_mod7(entry.weekday);
   assign cw    = wday_mod7(cur.weekday);
   assign wdiff = (tw >= cw) ? 3'(tw - cw) : 3'(tw + 3'd7 - cw);

   always_comb begin
      if (entry.weekly) begin
         days = ((wdiff == 3'd0) && passed) ? 3'd7 : wdiff;
      end else begin
         days = {2'b00, passed};
      end
   end

   assign day_part = SEC_W'(days) * SEC_W'(DAY_SEC);

   assign diff = $signed({2'b00, day_part}) + $signed({5'b00000, target})
               - $signed({5'b00000, cur.total});

   assign seconds = (diff < 22'sd1) ? SEC_W'(1) : diff[SEC_W-1:0];

endmodule

### design/weekly_alarm_next_select_unit.sv
// Seven-entry daily/weekly alarm scheduler with one shared seconds unit and a scan sequencer.
//
//  channel  | ports                          | beat
//  ---------+--------------------------------+--------------------------------------
//  request  | req_tvalid/tready/tdata[47:0]  | one action plus the current time
//  response | rsp_tvalid/tready/tdata[47:0]  | schedule, masks and fire result
//  csr      | csr_valid/ready/index/data     | text count register write
//
//  A write, fire, stop or toggle without a scan goes through the act state
//  straight to done; a reschedule scan steps the seconds unit over the seven
//  entries one per cycle, and a rotating fire runs the text index wrap as an
//  8-step restoring remainder.
//  Synchronous active-high reset: all entries disabled and zero, no schedule.
//  A finished response sits in an output register; the next request is taken
//  while it waits, and the sequencer only holds in its last state if the
//  output register is still full.
module weekly_alarm_next_select_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // action[2:0] entry_index[5:3] set_hour[10:6] set_minute[16:11] set_weekly[17]
   // set_weekday[20:18] set_enabled[21] set_rotating[22] now_weekday[25:23]
   // now_hour[30:26] now_minute[36:31] now_second[42:37], zero fill above
   input  logic [wans_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // scheduled_index[2:0] seconds_until[22:3] alerting_mask[29:23]
   // enabled_mask[36:30] fired[37] fired_text_index[45:38] status[46], zero fill above
   output logic [wans_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [7:0]                  csr_data
);
   import wans_pkg::*;

   state_type              state_ff, state_in;
   req_item_type           item_ff;
   entry_type              entry_ff [ENTRY_COUNT];
   logic [CNT_W-1:0]       pos_ff [ENTRY_COUNT];
   logic [ENTRY_COUNT-1:0] en_ff;
   logic [ENTRY_COUNT-1:0] alert_ff;
   logic [IDX_W-1:0]       sched_ff;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [SEC_W-1:0]       best_time_ff;
   logic [IDX_W-1:0]       scan_cnt_ff;
   logic [2:0]             mod_cnt_ff;
   logic [CNT_W-1:0]       daily_cnt_ff, weekly_cnt_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [CNT_W-1:0]       div_ff;
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic [DAY_W-1:0]       now_total_ff;
   logic                   fired_ff;
   logic [CNT_W-1:0]       fired_text_ff;
   logic                   status_ff;
   logic                   rsp_valid_ff;
   rsp_item_type           rsp_data_ff, rsp_q, rsp_in;

   logic                   req_fire;
   logic                   idx_ok;
   logic                   bad_idx;
   logic                   all_en;
   logic                   resched;
   logic                   rot_fire;
   logic [IDX_W-1:0]       rd_idx;
   entry_type              rd_entry;
   now_type                cur;
   logic [SEC_W-1:0]       secs;
   logic                   elig;
   logic                   take;
   logic                   scan_last;
   logic                   out_load;
   logic [CNT_W:0]         mod_shift;
   logic                   mod_ge;
   logic [CNT_W-1:0]       cnt_eff;

   // ---------------- decode of the held request ----------------
   assign idx_ok  = item_ff.entry_index < IDX_W'(ENTRY_COUNT);
   assign bad_idx = !idx_ok && ((item_ff.action == ACT_WRITE) ||
                                (item_ff.action == ACT_STOP) ||
                                (item_ff.action == ACT_ENABLE));
   assign all_en  = &en_ff;

   always_comb begin
      resched = 1'b0;
      unique case (item_ff.action)
         ACT_RESCHED: resched = 1'b1;
         ACT_STOP:    resched = idx_ok && alert_ff[item_ff.entry_index];
         ACT_TOGGLE:  resched = !all_en;
         ACT_ENABLE:  resched = idx_ok;
         default:     resched = 1'b0;
      endcase
   end

   // single read port into the entry table
   assign rd_idx   = (state_ff == ST_SCAN) ? scan_cnt_ff : sched_ff;
   assign rd_entry = (rd_idx != NO_ENTRY) ? entry_ff[rd_idx] : '0;

   assign rot_fire = (item_ff.action == ACT_FIRE) && (sched_ff != NO_ENTRY) &&
                     rd_entry.rotating;

   assign cnt_eff  = rd_entry.weekly ? weekly_cnt_ff : daily_cnt_ff;

   assign cur.weekday = item_ff.now_weekday;
   assign cur.hour    = item_ff.now_hour;
   assign cur.minute  = item_ff.now_minute;
   assign cur.total   = now_total_ff;

   wans_secs u_secs (
      .entry   (rd_entry),
      .cur     (cur),
      .seconds (secs)
   );

   // scan compare
   assign elig        = en_ff[scan_cnt_ff] && !alert_ff[scan_cnt_ff];
   assign take        = elig && ((best_idx_ff == NO_ENTRY) || (secs < best_time_ff));
   assign best_idx_in = take ? scan_cnt_ff : best_idx_ff;
   assign scan_last   = scan_cnt_ff == IDX_W'(ENTRY_COUNT - 1);

   // one restoring remainder step
   assign mod_shift = {rem_ff, div_ff[mod_cnt_ff]};
   assign mod_ge    = mod_shift >= {1'b0, cnt_ff};
   assign rem_in    = mod_ge ? CNT_W'(mod_shift - {1'b0, cnt_ff}) : mod_shift[CNT_W-1:0];

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_ACT;
         ST_ACT: begin
            if (rot_fire)     state_in = ST_MOD;
            else if (resched) state_in = ST_SCAN;
            else              state_in = ST_DONE;
         end
         ST_MOD:  if (mod_cnt_ff == 3'd0) state_in = ST_DONE;
         ST_SCAN: if (scan_last) state_in = ST_DONE;
         ST_DONE: if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_DONE: out_load   = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign req_fire  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   always_comb begin
      rsp_in                  = '0;
      rsp_in.scheduled_index  = sched_ff;
      rsp_in.seconds_until    = (sched_ff != NO_ENTRY) ? secs : '0;
      rsp_in.alerting_mask    = alert_ff;
      rsp_in.enabled_mask     = en_ff;
      rsp_in.fired            = fired_ff;
      rsp_in.fired_text_index = fired_text_ff;
      rsp_in.status           = status_ff;
   end

   // ---------------- control and table state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         en_ff         <= '0;
         alert_ff      <= '0;
         sched_ff      <= NO_ENTRY;
         best_idx_ff   <= NO_ENTRY;
         scan_cnt_ff   <= '0;
         mod_cnt_ff    <= '0;
         daily_cnt_ff  <= CNT_W'(1);
         weekly_cnt_ff <= CNT_W'(1);
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < ENTRY_COUNT; i++) begin
            entry_ff[i] <= '0;
            pos_ff[i]   <= '0;
         end
      end else begin
         state_ff <= state_in;

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_DAILY:  daily_cnt_ff  <= csr_data;
               CSR_WEEKLY: weekly_cnt_ff <= csr_data;
               default: ;
            endcase
         end

         if (state_ff == ST_ACT) begin
            best_idx_ff <= NO_ENTRY;
            scan_cnt_ff <= '0;
            mod_cnt_ff  <= 3'd7;
            unique case (item_ff.action)
               ACT_WRITE: begin
                  if (idx_ok) begin
                     entry_ff[item_ff.entry_index] <= '{hour:     item_ff.set_hour,
                                                        minute:   item_ff.set_minute,
                                                        weekly:   item_ff.set_weekly,
                                                        weekday:  item_ff.set_weekday,
                                                        rotating: item_ff.set_rotating};
                     en_ff[item_ff.entry_index] <= item_ff.set_enabled;
                  end
               end
               ACT_FIRE: begin
                  if (sched_ff != NO_ENTRY) alert_ff[sched_ff] <= 1'b1;
               end
               ACT_STOP: begin
                  if (idx_ok) alert_ff[item_ff.entry_index] <= 1'b0;
               end
               ACT_TOGGLE: begin
                  en_ff <= all_en ? '0 : '1;
                  if (all_en) sched_ff <= NO_ENTRY;
               end
               ACT_ENABLE: begin
                  if (idx_ok) en_ff[item_ff.entry_index] <= 1'b1;
               end
               default: ;
            endcase
         end

         if (state_ff == ST_MOD) begin
            mod_cnt_ff <= mod_cnt_ff - 3'd1;
            if (mod_cnt_ff == 3'd0) pos_ff[sched_ff] <= rem_in;
         end

         if (state_ff == ST_SCAN) begin
            best_idx_ff <= best_idx_in;
            scan_cnt_ff <= scan_cnt_ff + IDX_W'(1);
            if (scan_last) sched_ff <= best_idx_in;
         end

         if (out_load)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (req_fire) item_ff <= req_item_type'(req_tdata);

      if (state_ff == ST_ACT) begin
         now_total_ff  <= DAY_W'(item_ff.now_hour) * DAY_W'(HOUR_SEC)
                        + DAY_W'(item_ff.now_minute) * DAY_W'(MIN_SEC)
                        + DAY_W'(item_ff.now_second);
         status_ff     <= bad_idx;
         // a zero count register acts as one
         cnt_ff        <= (cnt_eff == '0) ? CNT_W'(1) : cnt_eff;
         rem_ff        <= '0;
         div_ff        <= (sched_ff != NO_ENTRY) ? CNT_W'(pos_ff[sched_ff] + CNT_W'(1)) : '0;
         fired_ff      <= (item_ff.action == ACT_FIRE) && (sched_ff != NO_ENTRY);
         fired_text_ff <= ((item_ff.action == ACT_FIRE) && (sched_ff != NO_ENTRY)) ?
                          pos_ff[sched_ff] : '0;
      end

      if (state_ff == ST_MOD) begin
         rem_ff <= rem_in;
         if (mod_cnt_ff == 3'd0) fired_text_ff <= rem_in;
      end

      if ((state_ff == ST_SCAN) && take) best_time_ff <= secs;

      if (out_load) rsp_data_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);
   assign rsp_q      = rsp_data_ff;

`ifndef SYNTHESIS
   a_fired_alerting: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_q.fired) |->
         ((rsp_q.scheduled_index != NO_ENTRY) &&
          (|(rsp_q.alerting_mask & (ENTRY_COUNT'(1) << rsp_q.scheduled_index)))))
      else $error("fired beat without the scheduled entry alerting");

   a_none_zero_secs: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_q.seconds_until == '0) == (rsp_q.scheduled_index == NO_ENTRY)))
      else $error("seconds_until and scheduled_index disagree");

   a_status_no_fire: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_q.status) |-> !rsp_q.fired)
      else $error("bad index beat also fired");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_cnt_ff < IDX_W'(ENTRY_COUNT)))
      else $error("scan counter past last entry");

   a_take_after_done: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_ACT))
      else $error("accepted request did not start the sequencer");
`endif

endmodule

### tb/tb.sv
// Self-checking stream testbench for the seven-entry weekly alarm scheduler.
module tb;
   import wans_pkg::*;

   // no handshake of any kind for this long means the block is hung; the longest
   // legal quiet spell is the forced output hold plus one scan
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 300;

   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_BAD_INDEX = 1'b1;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic       weekly;
      logic [2:0] weekday;
      logic       enabled;
      logic       rotating;
   } alarm_slot_type;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_index;
   logic [7:0]         csr_data;

   // shadow copy of the alarm bank
   alarm_slot_type         slot_tbl [ENTRY_COUNT];
   logic [7:0]             text_pos [ENTRY_COUNT];
   logic [ENTRY_COUNT-1:0] alert_bits;
   logic [IDX_W-1:0]       next_slot;
   logic [7:0]             daily_count;
   logic [7:0]             weekly_count;

   rsp_item_type schedule_replies[$];

   int sender_idle_pct;
   int stall_pct;
   int hold_left;
   int mismatches;
   int items_sent;
   int replies_seen;
   int fires_seen;
   int csr_writes;

   weekly_alarm_next_select_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int secs_to_slot(int i, req_item_type r);
      int   now_s;
      int   tgt;
      int   days;
      int   d;
      logic passed;
      now_s  = int'(r.now_hour) * HOUR_SEC + int'(r.now_minute) * MIN_SEC
               + int'(r.now_second);
      tgt    = int'(slot_tbl[i].hour) * HOUR_SEC + int'(slot_tbl[i].minute) * MIN_SEC;
      passed = (slot_tbl[i].hour < r.now_hour) ||
               (slot_tbl[i].hour == r.now_hour && slot_tbl[i].minute <= r.now_minute);
      if (slot_tbl[i].weekly) begin
         days = ((int'(slot_tbl[i].weekday) % 7) - (int'(r.now_weekday) % 7) + 7) % 7;
         if (days == 0 && passed) days = 7;
      end else begin
         days = passed ? 1 : 0;
      end
      d = days * DAY_SEC + tgt - now_s;
      if (d < 1) d = 1;
      return d;
   endfunction

   function automatic logic [IDX_W-1:0] pick_next(req_item_type r);
      logic [IDX_W-1:0] best;
      int               best_t;
      int               t;
      best   = NO_ENTRY;
      best_t = 0;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         if (slot_tbl[i].enabled && !alert_bits[i]) begin
            t = secs_to_slot(i, r);
            if (best == NO_ENTRY || t < best_t) begin
               best   = IDX_W'(i);
               best_t = t;
            end
         end
      end
      return best;
   endfunction

   function automatic rsp_item_type step_alarm_bank(req_item_type r);
      rsp_item_type o;
      logic         idx_ok;
      logic         all_on;
      int           idx;
      int           s;
      int           cnt;
      o      = '0;
      idx    = int'(r.entry_index);
      idx_ok = idx < ENTRY_COUNT;
      case (r.action)
         ACT_WRITE: begin
            if (!idx_ok) o.status = STATUS_BAD_INDEX;
            else begin
               slot_tbl[idx].hour     = r.set_hour;
               slot_tbl[idx].minute   = r.set_minute;
               slot_tbl[idx].weekly   = r.set_weekly;
               slot_tbl[idx].weekday  = r.set_weekday;
               slot_tbl[idx].enabled  = r.set_enabled;
               slot_tbl[idx].rotating = r.set_rotating;
            end
         end
         ACT_RESCHED: next_slot = pick_next(r);
         ACT_FIRE: begin
            if (next_slot < ENTRY_COUNT) begin
               s = int'(next_slot);
               if (slot_tbl[s].rotating) begin
                  cnt = slot_tbl[s].weekly ? int'(weekly_count) : int'(daily_count);
                  if (cnt == 0) cnt = 1;
                  text_pos[s] = 8'((int'(text_pos[s]) + 1) % cnt);
               end
               alert_bits[s]      = 1'b1;
               o.fired            = 1'b1;
               o.fired_text_index = text_pos[s];
            end
         end
         ACT_STOP: begin
            if (!idx_ok) o.status = STATUS_BAD_INDEX;
            else if (alert_bits[idx]) begin
               alert_bits[idx] = 1'b0;
               next_slot       = pick_next(r);
            end
         end
         ACT_TOGGLE: begin
            all_on = 1'b1;
            for (int i = 0; i < ENTRY_COUNT; i++)
               if (!slot_tbl[i].enabled) all_on = 1'b0;
            for (int i = 0; i < ENTRY_COUNT; i++)
               slot_tbl[i].enabled = !all_on;
            if (all_on) next_slot = NO_ENTRY;
            else next_slot = pick_next(r);
         end
         ACT_ENABLE: begin
            if (!idx_ok) o.status = STATUS_BAD_INDEX;
            else begin
               slot_tbl[idx].enabled = 1'b1;
               next_slot             = pick_next(r);
            end
         end
         default: o.status = STATUS_OK;
      endcase
      o.scheduled_index = next_slot;
      o.seconds_until   = (next_slot < ENTRY_COUNT) ?
                          SEC_W'(secs_to_slot(int'(next_slot), r)) : '0;
      o.alerting_mask   = alert_bits;
      for (int i = 0; i < ENTRY_COUNT; i++)
         o.enabled_mask[i] = slot_tbl[i].enabled;
      return o;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic req_item_type make_item(logic [2:0] act, int idx, int h, int m,
                                              int wk, int wd, int en, int rot,
                                              int nwd, int nh, int nm, int ns);
      req_item_type r;
      r              = '0;
      r.action       = act;
      r.entry_index  = 3'(idx);
      r.set_hour     = 5'(h);
      r.set_minute   = 6'(m);
      r.set_weekly   = 1'(wk);
      r.set_weekday  = 3'(wd);
      r.set_enabled  = 1'(en);
      r.set_rotating = 1'(rot);
      r.now_weekday  = 3'(nwd);
      r.now_hour     = 5'(nh);
      r.now_minute   = 6'(nm);
      r.now_second   = 6'(ns);
      return r;
   endfunction

   // mostly legal times and indexes; fires and stops are weighted so entries
   // cycle through alerting and back, and "now" often lands on an entry's time
   function automatic req_item_type make_random_item();
      req_item_type r;
      int           pick;
      int           k;
      r    = '0;
      pick = $urandom_range(0, 99);
      if (pick < 18)      r.action = ACT_WRITE;
      else if (pick < 33) r.action = ACT_RESCHED;
      else if (pick < 58) r.action = ACT_FIRE;
      else if (pick < 78) r.action = ACT_STOP;
      else if (pick < 83) r.action = ACT_TOGGLE;
      else if (pick < 96) r.action = ACT_ENABLE;
      else                r.action = $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;

      r.entry_index = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      if (r.action == ACT_STOP && alert_bits != '0 && $urandom_range(0, 4) != 0) begin
         do k = $urandom_range(0, ENTRY_COUNT - 1); while (!alert_bits[k]);
         r.entry_index = 3'(k);
      end

      r.set_hour     = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 23));
      r.set_minute   = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(0, 59));
      r.set_weekly   = 1'($urandom_range(0, 1));
      r.set_weekday  = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      r.set_enabled  = ($urandom_range(0, 99) < 85);
      r.set_rotating = 1'($urandom_range(0, 1));

      r.now_weekday  = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      r.now_hour     = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                   : 5'($urandom_range(0, 23));
      r.now_minute   = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(0, 59));
      r.now_second   = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(60, 63))
                                                   : 6'($urandom_range(0, 59));
      if ($urandom_range(0, 3) == 0) begin
         k            = $urandom_range(0, ENTRY_COUNT - 1);
         r.now_hour   = slot_tbl[k].hour;
         r.now_minute = slot_tbl[k].minute;
         if ($urandom_range(0, 1)) r.now_weekday = slot_tbl[k].weekday;
      end
      return r;
   endfunction

   task automatic send_alarm_beat(req_item_type r);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = r;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      schedule_replies.push_back(step_alarm_bank(r));
      items_sent++;
   endtask

   task automatic idle_until_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (schedule_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_text_count(logic which, logic [7:0] value);
      @(negedge clock);
      csr_index = which;
      csr_data  = value;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (which == CSR_DAILY) daily_count = value;
      else weekly_count = value;
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic run_random_burst(int n);
      repeat (n) send_alarm_beat(make_random_item());
   endtask

   // ---------------------------------------------------------------- reply side

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("reply %0d: %s expected %0d, got %0d", replies_seen, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         replies_seen++;
         if (got.fired === 1'b1) fires_seen++;
         if (schedule_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("reply %0d arrived with no request outstanding: %h",
                        replies_seen, rsp_tdata);
         end else begin
            want = schedule_replies.pop_front();
            check_field("scheduled_index", 32'(want.scheduled_index),
                        32'(got.scheduled_index));
            check_field("seconds_until", 32'(want.seconds_until), 32'(got.seconds_until));
            check_field("alerting_mask", 32'(want.alerting_mask), 32'(got.alerting_mask));
            check_field("enabled_mask", 32'(want.enabled_mask), 32'(got.enabled_mask));
            check_field("fired", 32'(want.fired), 32'(got.fired));
            check_field("fired_text_index", 32'(want.fired_text_index),
                        32'(got.fired_text_index));
            check_field("status", 32'(want.status), 32'(got.status));
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("no handshake for %0d cycles, giving up", QUIET_LIMIT);
      $display("weekly_alarm_next_select_unit test failed");
      $finish;
   end

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      sender_idle_pct = 0;
      stall_pct       = 0;
      write_text_count(CSR_DAILY, 8'd3);
      write_text_count(CSR_WEEKLY, 8'd2);
      send_alarm_beat(make_item(ACT_RESCHED, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_alarm_beat(make_item(ACT_FIRE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_alarm_beat(make_item(ACT_WRITE, 7, 23, 59, 1, 6, 1, 1, 1, 1, 1, 1));
      send_alarm_beat(make_item(ACT_STOP, 7, 0, 0, 0, 0, 0, 0, 2, 3, 4, 5));
      send_alarm_beat(make_item(ACT_ENABLE, 7, 0, 0, 0, 0, 0, 0, 2, 3, 4, 5));
      send_alarm_beat(make_item(ACT_SPARE_LO, 0, 31, 63, 1, 7, 1, 1, 7, 31, 63, 63));
      send_alarm_beat(make_item(ACT_SPARE_HI, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_alarm_beat(make_item(ACT_WRITE, 0, 7, 30, 0, 0, 1, 1, 0, 0, 0, 0));
      send_alarm_beat(make_item(ACT_WRITE, 1, 23, 59, 1, 3, 1, 1, 0, 0, 0, 0));
      // weekday 7 and an hour/minute past their range
      send_alarm_beat(make_item(ACT_WRITE, 2, 31, 63, 1, 7, 1, 0, 0, 0, 0, 0));
      send_alarm_beat(make_item(ACT_WRITE, 3, 10, 1, 0, 0, 1, 0, 0, 0, 0, 0));
      // second 63 puts "now" past 10:01, so the distance clamps to one second
      send_alarm_beat(make_item(ACT_RESCHED, 0, 0, 0, 0, 0, 0, 0, 6, 10, 0, 63));
      send_alarm_beat(make_item(ACT_FIRE, 0, 0, 0, 0, 0, 0, 0, 6, 10, 0, 63));
      send_alarm_beat(make_item(ACT_STOP, 3, 0, 0, 0, 0, 0, 0, 6, 10, 0, 63));
      send_alarm_beat(make_item(ACT_STOP, 3, 0, 0, 0, 0, 0, 0, 5, 1, 2, 3));
      // weekly entry on its own day, already passed: a full week out
      send_alarm_beat(make_item(ACT_RESCHED, 0, 0, 0, 0, 0, 0, 0, 3, 23, 59, 0));
      send_alarm_beat(make_item(ACT_RESCHED, 0, 0, 0, 0, 0, 0, 0, 0, 7, 29, 59));
      send_alarm_beat(make_item(ACT_FIRE, 0, 0, 0, 0, 0, 0, 0, 0, 7, 30, 0));
      send_alarm_beat(make_item(ACT_ENABLE, 4, 0, 0, 0, 0, 0, 0, 4, 12, 0, 0));
      send_alarm_beat(make_item(ACT_TOGGLE, 0, 0, 0, 0, 0, 0, 0, 4, 12, 0, 0));
      send_alarm_beat(make_item(ACT_TOGGLE, 0, 0, 0, 0, 0, 0, 0, 4, 12, 0, 0));
      send_alarm_beat(make_item(ACT_ENABLE, 1, 0, 0, 0, 0, 0, 0, 3, 23, 59, 0));
      send_alarm_beat(make_item(ACT_FIRE, 0, 0, 0, 0, 0, 0, 0, 3, 23, 59, 0));
      send_alarm_beat(make_item(ACT_STOP, 0, 0, 0, 0, 0, 0, 0, 7, 31, 63, 63));
   endtask

   task automatic test_streaming();
      idle_until_drained();
      write_text_count(CSR_DAILY, 8'd255);
      write_text_count(CSR_WEEKLY, 8'd1);
      sender_idle_pct = 0;
      stall_pct       = 0;
      run_random_burst(140);
   endtask

   task automatic test_sender_gaps();
      idle_until_drained();
      // a zero count behaves as one
      write_text_count(CSR_DAILY, 8'd0);
      write_text_count(CSR_WEEKLY, 8'd255);
      sender_idle_pct = 60;
      stall_pct       = 0;
      run_random_burst(140);
   endtask

   task automatic test_receiver_stalls();
      idle_until_drained();
      write_text_count(CSR_DAILY, 8'd1);
      write_text_count(CSR_WEEKLY, 8'd0);
      sender_idle_pct = 0;
      stall_pct       = 60;
      run_random_burst(140);
   endtask

   task automatic test_mixed_idling();
      idle_until_drained();
      write_text_count(CSR_DAILY, 8'($urandom_range(2, 9)));
      write_text_count(CSR_WEEKLY, 8'($urandom_range(1, 254)));
      sender_idle_pct = 24;
      stall_pct       = 24;
      run_random_burst(140);
   endtask

   task automatic test_output_backlog();
      idle_until_drained();
      sender_idle_pct = 0;
      stall_pct       = 0;
      hold_left       = HOLD_CYCLES;
      run_random_burst(40);
   endtask

   task automatic test_drain_pause();
      idle_until_drained();
      write_text_count(CSR_DAILY, 8'($urandom_range(1, 254)));
      write_text_count(CSR_WEEKLY, 8'($urandom_range(2, 5)));
      sender_idle_pct = 24;
      stall_pct       = 24;
      run_random_burst(25);
      idle_until_drained();
      run_random_burst(25);
   endtask

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_DAILY;
      csr_data        = '0;
      sender_idle_pct = 0;
      stall_pct       = 0;
      hold_left       = 0;
      mismatches      = 0;
      items_sent      = 0;
      replies_seen    = 0;
      fires_seen      = 0;
      csr_writes      = 0;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         slot_tbl[i] = '0;
         text_pos[i] = '0;
      end
      alert_bits   = '0;
      next_slot    = NO_ENTRY;
      daily_count  = 8'd1;
      weekly_count = 8'd1;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_streaming();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();
      test_output_backlog();
      test_drain_pause();
      idle_until_drained();

      if (schedule_replies.size() != 0) begin
         mismatches += schedule_replies.size();
         $display("%0d replies never arrived", schedule_replies.size());
      end
      $display("ran %0d requests, %0d replies checked, %0d alarms set off, %0d count writes",
               items_sent, replies_seen, fires_seen, csr_writes);
      $display("idle patterns: none, sender gaps, receiver stalls, both, a %0d-cycle hold",
               HOLD_CYCLES);
      if (mismatches == 0)
         $display("weekly_alarm_next_select_unit test passed");
      else
         $display("weekly_alarm_next_select_unit test failed");
      $finish;
   end

endmodule

### filelist.f
design/wans_pkg.sv
design/wans_secs.sv
design/weekly_alarm_next_select_unit.sv
tb/tb.sv
